@@ hdl/bbia_pkg.sv @@
// ----------------------------------------------------------------------------
// bbia_pkg
// Shared constants and a helper for the banked buffer ID allocator.
// ----------------------------------------------------------------------------
package bbia_pkg;

    localparam int BANKS_DEF         = 16;
    localparam int BUFS_PER_POOL_DEF = 256;
    localparam int CLIENTS_DEF       = 8;
    localparam int POOLS_DEF         = 3;

    localparam logic [1:0] FUNC_ALLOC_CREDIT = 2'd0;
    localparam logic [1:0] FUNC_ALLOC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_RELEASE      = 2'd2;
    localparam logic [1:0] FUNC_ADJUST       = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CREDIT  = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_NOP     = 2'd3;

    typedef struct packed {
        logic       granted;
        logic [7:0] granted_index;
        logic [1:0] status;
        logic       pool_wake;
        logic       credit_wake;
    } bbia_result_t;

    // Saturating add of a 9-bit signed change to an 8-bit signed credit.
    function automatic logic signed [7:0] sat_add(input logic signed [7:0] a,
                                                   input logic signed [8:0] d);
        logic signed [9:0] s;
        s = 10'(a) + 10'(d);
        if (s > 10'sd127)
            return 8'sd127;
        else if (s < -10'sd128)
            return -8'sd128;
        else
            return s[7:0];
    endfunction

endpackage

@@ hdl/bbia_ram.sv @@
// ----------------------------------------------------------------------------
// bbia_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bbia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/banked_buffer_id_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// banked_buffer_id_allocator_unit
// Buffer ID allocator with per-pool LIFO banks and per-client credits.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transaction: func, pool, requester,
//   client_id, buffer_index and credit_delta packed in tdata. m_axis returns
//   one result per request: granted, granted_index, status, pool_wake and
//   credit_wake.
//   The accept cycle decides the bank from the fill counters held in flops
//   (a priority find over the non-empty bits starting at the requester's
//   bank), issues a read of that bank top and writes a released ID into the
//   bank RAM. The next cycle merges the read data into the result register.
//   A request is accepted only in the idle state, so a new request is not
//   taken until the last one has passed the execute state, and the result
//   is valid once the execute state has registered it.
//   The result sits in an output register; a new request is accepted when
//   that register is empty or is drained in the same cycle, so a receiver
//   stall holds s_axis_tready low until the result is taken.
//   After reset the bank RAM is not yet filled: a clearing pass writes
//   every entry with its initial ID, one entry a cycle, during which
//   s_axis_tready is low.
// ----------------------------------------------------------------------------
module banked_buffer_id_allocator_unit
    import bbia_pkg::*;
#(
    parameter int BANKS         = BANKS_DEF,
    parameter int BUFS_PER_POOL = BUFS_PER_POOL_DEF,
    parameter int CLIENTS       = CLIENTS_DEF,
    parameter int POOLS         = POOLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[1:0], pool[3:2], requester[7:4], client_id[10:8],
    // buffer_index[18:11], credit_delta[26:19], zero[31:27]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // granted[0], granted_index[8:1], status[10:9], pool_wake[11],
    // credit_wake[12], zero[15:13]
    output logic [15:0] m_axis_tdata
);

    localparam int DEPTH  = (BUFS_PER_POOL + BANKS - 1) / BANKS;
    localparam int BW     = $clog2(BANKS);
    localparam int DW     = $clog2(DEPTH);
    localparam int FW     = $clog2(DEPTH + 1);
    localparam int CW     = $clog2(BUFS_PER_POOL + 1);
    localparam int PW     = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int KW     = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int MDEPTH = POOLS * BANKS * DEPTH;
    localparam int AW     = $clog2(MDEPTH);

    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     init_reg;
    logic [BW-1:0]     ibank_reg;
    logic [DW-1:0]     islot_reg;
    logic [FW-1:0]     fill_reg [POOLS][BANKS];
    logic [CW-1:0]     cnt_reg  [POOLS];
    logic signed [7:0] cred_reg [CLIENTS];
    bbia_result_t      res_reg;
    logic              ovalid_reg;

    // Request fields
    logic [1:0] f_func, f_pool;
    logic [3:0] f_req;
    logic [2:0] f_cid;
    logic [7:0] f_idx;
    logic signed [7:0] f_delta;
    assign f_func  = s_axis_tdata[1:0];
    assign f_pool  = s_axis_tdata[3:2];
    assign f_req   = s_axis_tdata[7:4];
    assign f_cid   = s_axis_tdata[10:8];
    assign f_idx   = s_axis_tdata[18:11];
    assign f_delta = s_axis_tdata[26:19];

    logic accept;
    assign s_axis_tready = (state_reg == S_IDLE) && (!ovalid_reg || m_axis_tready);
    assign accept = s_axis_tvalid && s_axis_tready;

    // Decision in the accept cycle
    logic              pool_ok, cid_ok, idx_ok;
    logic [PW-1:0]     pi;
    logic [KW-1:0]     ci;
    logic signed [7:0] cred;
    logic [BW-1:0]     start, bsel, bcand, ib;
    logic [BW:0]       bsum;
    logic              found;
    logic [FW-1:0]     fsel;
    bbia_result_t      dec;
    logic              do_pop, do_push;
    logic [AW-1:0]     raddr, waddr_c;

    always_comb
    begin
        pool_ok = 32'(f_pool) < POOLS;
        cid_ok  = 32'(f_cid) < CLIENTS;
        idx_ok  = 32'(f_idx) < BUFS_PER_POOL;
        pi      = pool_ok ? f_pool[PW-1:0] : '0;
        ci      = cid_ok ? f_cid[KW-1:0] : '0;
        cred    = cred_reg[ci];
        // bank of the requester and of the released ID, decoded from constant tables
        start   = '0;
        for (int r = 0; r < 16; r++)
            if (f_req == 4'(r))
                start = BW'(r % BANKS);
        ib      = '0;
        for (int r = 0; r < 256; r++)
            if (f_idx == 8'(r))
                ib = BW'(r % BANKS);
        found   = 1'b0;
        bsel    = '0;
        for (int k = 0; k < BANKS; k++)
        begin
            bsum = {1'b0, start} + {1'b0, BW'(k)};
            if (32'(bsum) >= BANKS)
                bsum = bsum - (BW+1)'(BANKS);
            bcand = bsum[BW-1:0];
            if (!found && fill_reg[pi][bcand] != '0)
            begin
                found = 1'b1;
                bsel  = bcand;
            end
        end
        do_pop  = 1'b0;
        do_push = 1'b0;
        dec     = '{granted: 1'b0, granted_index: '0, status: ST_NOP,
                    pool_wake: 1'b0, credit_wake: 1'b0};
        unique case (f_func)
            FUNC_ALLOC_CREDIT, FUNC_ALLOC_FREE:
            begin
                if (!pool_ok || (f_func == FUNC_ALLOC_CREDIT && !cid_ok))
                    dec.status = ST_NOP;
                else if (f_func == FUNC_ALLOC_CREDIT && cred <= 0)
                    dec.status = ST_CREDIT;
                else if (cnt_reg[pi] == '0 || !found)
                    dec.status = ST_EMPTY;
                else
                begin
                    dec.status  = ST_OK;
                    dec.granted = 1'b1;
                    do_pop      = 1'b1;
                end
            end
            FUNC_RELEASE:
            begin
                if (pool_ok && cid_ok && idx_ok && 32'(fill_reg[pi][ib]) < DEPTH)
                begin
                    dec.status      = ST_OK;
                    do_push         = 1'b1;
                    dec.pool_wake   = 32'(cnt_reg[pi]) == BUFS_PER_POOL / 4;
                    dec.credit_wake = cred == 8'sd1;
                end
            end
            default:
            begin
                if (cid_ok)
                begin
                    dec.status      = ST_OK;
                    dec.credit_wake = f_delta != 8'sd0;
                end
            end
        endcase
        fsel    = fill_reg[pi][bsel] - FW'(1);
        raddr   = AW'((32'(pi) * BANKS + 32'(bsel)) * DEPTH + 32'(fsel[DW-1:0]));
        waddr_c = AW'((32'(pi) * BANKS + 32'(ib)) * DEPTH + 32'(fill_reg[pi][ib]));
    end

    // RAM write: clearing pass or push
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata, rdata;
    always_comb
    begin
        if (state_reg == S_INIT)
        begin
            we    = 1'b1;
            waddr = init_reg;
            wdata = 8'(32'(ibank_reg) + 32'(islot_reg) * BANKS);
        end
        else
        begin
            we    = accept && do_push;
            waddr = waddr_c;
            wdata = f_idx;
        end
    end

    bbia_ram #(.WIDTH(8), .DEPTH(MDEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:  if (32'(init_reg) == MDEPTH - 1) state_next = S_IDLE;
            S_IDLE:  if (accept) state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_INIT;
        endcase
    end

    logic signed [8:0] cchg;
    always_comb
    begin
        cchg = '0;
        if (f_func == FUNC_ALLOC_CREDIT && do_pop)
            cchg = -9'sd1;
        else if (do_push)
            cchg = 9'sd1;
        else if (f_func == FUNC_ADJUST && cid_ok)
            cchg = 9'(f_delta);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            init_reg   <= '0;
            ibank_reg  <= '0;
            islot_reg  <= '0;
            ovalid_reg <= 1'b0;
            for (int p = 0; p < POOLS; p++)
            begin
                cnt_reg[p] <= CW'(BUFS_PER_POOL);
                for (int b = 0; b < BANKS; b++)
                    fill_reg[p][b] <= FW'((BUFS_PER_POOL - b + BANKS - 1) / BANKS);
            end
            for (int c = 0; c < CLIENTS; c++)
                cred_reg[c] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_INIT)
            begin
                init_reg <= init_reg + AW'(1);
                // advance slot, then bank, wrapping per pool
                if (islot_reg == DW'(DEPTH - 1))
                begin
                    islot_reg <= '0;
                    if (ibank_reg == BW'(BANKS - 1))
                        ibank_reg <= '0;
                    else
                        ibank_reg <= ibank_reg + BW'(1);
                end
                else
                    islot_reg <= islot_reg + DW'(1);
            end
            if (state_reg == S_EXEC)
                ovalid_reg <= 1'b1;
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
            if (accept)
            begin
                if (do_pop)
                begin
                    fill_reg[pi][bsel] <= fsel;
                    cnt_reg[pi]        <= cnt_reg[pi] - CW'(1);
                end
                if (do_push)
                begin
                    fill_reg[pi][ib] <= fill_reg[pi][ib] + FW'(1);
                    cnt_reg[pi]      <= cnt_reg[pi] + CW'(1);
                end
                if (cchg != '0)
                    cred_reg[ci] <= sat_add(cred, cchg);
            end
        end
    end

    // Payload: hold the decision, merge the popped ID in the execute state
    bbia_result_t dec_reg;
    bbia_result_t res_next;
    always_comb
    begin
        res_next = dec_reg;
        if (dec_reg.granted)
            res_next.granted_index = rdata;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            dec_reg <= dec;
        if (state_reg == S_EXEC)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {3'b000, res_reg.credit_wake, res_reg.pool_wake,
                            res_reg.status, res_reg.granted_index, res_reg.granted};

endmodule

@@ hdl/bbia_checker.sv @@
// ----------------------------------------------------------------------------
// bbia_checker
// Port-level checks for the buffer ID allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bbia_checker
    import bbia_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A grant always reports ok status
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[10:9] == ST_OK)
        else $error("grant without ok status");

    // No grant means index zero
    a_nogrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
        else $error("index without grant");

    // An accepted request is followed by a valid result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("result missing");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind banked_buffer_id_allocator_unit bbia_checker u_bbia_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus, prediction and checking for the banked buffer ID allocator: a
// queue-fed driver, a monitor comparing each result with a local model of the
// pools, banks and client credits, random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb;
    import bbia_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBANK  = 16;
    localparam int NBUF   = 256;
    localparam int NCLI   = 8;
    localparam int NPOOL  = 3;
    localparam int DEPTH  = NBUF / NBANK;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic signed [7:0] credit_delta;
        logic [7:0]        buffer_index;
        logic [2:0]        client_id;
        logic [3:0]        requester;
        logic [1:0]        pool;
        logic [1:0]        func;
    } request_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    banked_buffer_id_allocator_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // allocator state mirror
    logic [7:0]        bank_ids [NPOOL][NBANK][DEPTH];
    int                bank_cnt [NPOOL][NBANK];
    int                free_ids [NPOOL];
    logic signed [7:0] credit   [NCLI];

    request_t     pending_reqs [$];
    bbia_result_t expected_results [$];
    logic [7:0]   held_ids [NPOOL][$];
    int           error_count;
    int           idle_cycles;
    int           send_gap;
    int           recv_gap;
    bit           stim_done;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [7:0] clamp_credit(input int v);
        if (v > 127)
            return 8'sd127;
        if (v < -128)
            return -8'sd128;
        return v[7:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic reset_mirror();
        for (int p = 0; p < NPOOL; p++)
        begin
            for (int b = 0; b < NBANK; b++)
            begin
                for (int k = 0; k < DEPTH; k++)
                    bank_ids[p][b][k] = 8'(b + k * NBANK);
                bank_cnt[p][b] = DEPTH;
            end
            free_ids[p] = NBUF;
        end
        for (int c = 0; c < NCLI; c++)
            credit[c] = 8'sd0;
    endtask

    // apply one request to the mirror and return what the block should give
    function automatic bbia_result_t predict_allocation(input request_t rq);
        bbia_result_t r;
        int b;
        int f;
        int prev;
        r = '0;
        r.status = ST_NOP;
        case (rq.func)
            FUNC_ALLOC_CREDIT, FUNC_ALLOC_FREE:
            begin
                if (rq.pool >= NPOOL || (rq.func == FUNC_ALLOC_CREDIT && rq.client_id >= NCLI))
                    r.status = ST_NOP;
                else if (rq.func == FUNC_ALLOC_CREDIT && credit[rq.client_id] <= 0)
                    r.status = ST_CREDIT;
                else if (free_ids[rq.pool] == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.status = ST_EMPTY;
                    b = rq.requester % NBANK;
                    for (int n = 0; n < NBANK; n++)
                    begin
                        if (bank_cnt[rq.pool][b] > 0)
                        begin
                            bank_cnt[rq.pool][b]--;
                            r.granted_index = bank_ids[rq.pool][b][bank_cnt[rq.pool][b]];
                            r.granted = 1'b1;
                            r.status = ST_OK;
                            free_ids[rq.pool]--;
                            if (rq.func == FUNC_ALLOC_CREDIT)
                                credit[rq.client_id] =
                                    clamp_credit(int'(credit[rq.client_id]) - 1);
                            break;
                        end
                        b = (b + 1) % NBANK;
                    end
                end
            end
            FUNC_RELEASE:
            begin
                if (rq.pool < NPOOL && rq.client_id < NCLI)
                begin
                    b = rq.buffer_index % NBANK;
                    f = bank_cnt[rq.pool][b];
                    if (f < DEPTH)
                    begin
                        prev = free_ids[rq.pool];
                        bank_ids[rq.pool][b][f] = rq.buffer_index;
                        bank_cnt[rq.pool][b] = f + 1;
                        free_ids[rq.pool] = prev + 1;
                        r.pool_wake = (prev == NBUF / 4);
                        r.credit_wake = (credit[rq.client_id] == 8'sd1);
                        credit[rq.client_id] = clamp_credit(int'(credit[rq.client_id]) + 1);
                        r.status = ST_OK;
                    end
                end
            end
            default:
            begin
                if (rq.client_id < NCLI)
                begin
                    r.status = ST_OK;
                    if (rq.credit_delta != 0)
                    begin
                        credit[rq.client_id] = clamp_credit(int'(credit[rq.client_id])
                                                            + int'(rq.credit_delta));
                        r.credit_wake = 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic request_t make_req(input logic [1:0] fn, input int pl,
                                          input int rqr, input int cid, input int idx,
                                          input int dlt);
        request_t q;
        q.func = fn;
        q.pool = 2'(pl);
        q.requester = 4'(rqr);
        q.client_id = 3'(cid);
        q.buffer_index = 8'(idx);
        q.credit_delta = 8'(dlt);
        return q;
    endfunction

    // keep a list of handed-out IDs per pool, so releases mostly return real ones
    task automatic queue_random_req();
        request_t q;
        int r;
        int p;
        int k;
        r = $urandom;
        q = request_t'(r[26:0]);
        q.client_id = 3'($urandom_range(0, 7));
        p = $urandom_range(0, 2);
        q.pool = 2'(p);
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            q.func = FUNC_ALLOC_CREDIT;
        end
        else if (r < 50)
        begin
            q.func = FUNC_ALLOC_FREE;
        end
        else if (r < 78)
        begin
            q.func = FUNC_RELEASE;
            if (held_ids[p].size() > 0 && $urandom_range(0, 9) < 8)
            begin
                k = $urandom_range(0, held_ids[p].size() - 1);
                q.buffer_index = held_ids[p][k];
                held_ids[p].delete(k);
            end
        end
        else
        begin
            q.func = FUNC_ADJUST;
            if ($urandom_range(0, 3) != 0)
                q.credit_delta = 8'($urandom_range(0, 12) - 4);
        end
        if ($urandom_range(0, 29) == 0)
            q.pool = 2'd3;
        pending_reqs.push_back(q);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                request_t q;
                bbia_result_t e;
                q = pending_reqs.pop_front();
                e = predict_allocation(q);
                if (e.granted)
                    held_ids[q.pool].push_back(e.granted_index);
                expected_results.push_back(e);
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {5'd0, q};
                send_gap      <= pick_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
            idle_cycles   <= 0;
        end
        else
        begin
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                bbia_result_t got;
                bbia_result_t want;
                got.granted       = m_axis_tdata[0];
                got.granted_index = m_axis_tdata[8:1];
                got.status        = m_axis_tdata[10:9];
                got.pool_wake     = m_axis_tdata[11];
                got.credit_wake   = m_axis_tdata[12];
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", int'(got), 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.granted !== want.granted)
                        report_mismatch("granted", got.granted, want.granted);
                    if (got.granted_index !== want.granted_index)
                        report_mismatch("granted_index", got.granted_index,
                                        want.granted_index);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.pool_wake !== want.pool_wake)
                        report_mismatch("pool_wake", got.pool_wake, want.pool_wake);
                    if (got.credit_wake !== want.credit_wake)
                        report_mismatch("credit_wake", got.credit_wake, want.credit_wake);
                end
                if (m_axis_tdata[15:13] !== 3'd0)
                    report_mismatch("tdata pad", m_axis_tdata[15:13], 0);
            end
            if (recv_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_gap      <= recv_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    recv_gap <= pick_gap();
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        error_count = 0;
        stim_done   = 1'b0;
        reset_mirror();
        // directed: field extremes, each operation, each special case
        pending_reqs.push_back(make_req(FUNC_ALLOC_CREDIT, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FUNC_ADJUST, 0, 0, 0, 0, 127));
        pending_reqs.push_back(make_req(FUNC_ADJUST, 0, 0, 0, 0, 127));
        pending_reqs.push_back(make_req(FUNC_ADJUST, 0, 0, 7, 255, -128));
        pending_reqs.push_back(make_req(FUNC_ADJUST, 0, 0, 7, 0, -128));
        pending_reqs.push_back(make_req(FUNC_ADJUST, 0, 0, 3, 0, 0));
        pending_reqs.push_back(make_req(FUNC_ALLOC_CREDIT, 0, 15, 0, 0, 0));
        pending_reqs.push_back(make_req(FUNC_ALLOC_CREDIT, 2, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FUNC_ALLOC_FREE, 1, 7, 5, 0, 0));
        pending_reqs.push_back(make_req(FUNC_ALLOC_FREE, 3, 7, 5, 0, 0));
        pending_reqs.push_back(make_req(FUNC_ALLOC_CREDIT, 3, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FUNC_RELEASE, 0, 0, 0, 255, 0));
        pending_reqs.push_back(make_req(FUNC_RELEASE, 3, 0, 0, 10, 0));
        pending_reqs.push_back(make_req(FUNC_RELEASE, 0, 0, 7, 255, 0));
        pending_reqs.push_back(make_req(FUNC_ADJUST, 0, 0, 1, 0, 1));
        pending_reqs.push_back(make_req(FUNC_RELEASE, 1, 0, 1, 23, 0));
        pending_reqs.push_back(make_req(FUNC_RELEASE, 2, 15, 4, 0, -1));
        // drain pool 2 to empty, wrapping the scan over every bank
        for (int i = 0; i < NBUF; i++)
            pending_reqs.push_back(make_req(FUNC_ALLOC_FREE, 2, i, 0, 0, 0));
        pending_reqs.push_back(make_req(FUNC_ALLOC_FREE, 2, 9, 0, 0, 0));
        // refill past the quarter mark to raise a pool wake
        for (int i = 0; i < 70; i++)
            pending_reqs.push_back(make_req(FUNC_RELEASE, 2, 0, 2, i * 3 % NBUF, 0));
        for (int i = 0; i < 706; i++)
            queue_random_req();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        while ((pending_reqs.size() > 0 || expected_results.size() > 0)
               && idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
        else
        begin
            repeat (20) @(posedge clk);
            if (error_count == 0 && expected_results.size() == 0)
                $display("tb: done, clean");
            else
                $display("tb: done, errors");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
hdl/bbia_pkg.sv
hdl/bbia_ram.sv
hdl/banked_buffer_id_allocator_unit.sv
hdl/bbia_checker.sv
sim/tb.sv
